### rtl/clx_pkg.sv
// Shared types, constants and keyword table for the C token lexer.
package clx_pkg;

  localparam int POS_W     = 16;
  localparam int LEN_W     = 6;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int NUM_KW    = 22;

  localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_CAP = 6'd63;
  localparam logic [4:0]       NOT_KW  = 5'd22;

  localparam logic [2:0] CLS_OP      = 3'd0;
  localparam logic [2:0] CLS_SPECIAL = 3'd1;
  localparam logic [2:0] CLS_NUMBER  = 3'd2;
  localparam logic [2:0] CLS_KEYWORD = 3'd3;
  localparam logic [2:0] CLS_IDENT   = 3'd4;
  localparam logic [2:0] CLS_STRING  = 3'd5;
  localparam logic [2:0] CLS_END     = 3'd6;

  typedef struct packed {
    logic [2:0]       cls;
    logic [7:0]       c1;
    logic [7:0]       c2;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [LEN_W-1:0] len;
    logic             over;
    logic [7:0][7:0]  pfx;
  } tok_t;

  // Tokens caused by one input byte.
  typedef struct packed {
    logic [1:0]    n;
    tok_t [1:0]    tok;
  } bundle_t;

  // Keywords as right-aligned strings with their lengths, in table order.
  localparam logic [63:0] KW_STR [NUM_KW] = '{
    64'("for"), 64'("if"), 64'("else"), 64'("while"), 64'("do"), 64'("break"),
    64'("continue"), 64'("return"), 64'("int"), 64'("double"), 64'("float"),
    64'("char"), 64'("long"), 64'("short"), 64'("sizeof"), 64'("typedef"),
    64'("switch"), 64'("case"), 64'("struct"), 64'("const"), 64'("void"),
    64'("exit")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd6, 4'd3, 4'd6, 4'd5,
    4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6, 4'd4, 4'd6, 4'd5, 4'd4, 4'd4
  };

  // Reorder a right-aligned string so its first byte sits in byte lane 0.
  function automatic logic [7:0][7:0] kw_pack(input logic [63:0] s, input logic [3:0] l);
    logic [7:0][7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(l)) r[i] = s[8*(int'(l)-1-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [4:0] kw_lookup(input logic [7:0][7:0] pfx,
                                           input logic [LEN_W-1:0] len,
                                           input logic over);
    logic [4:0] k;
    k = NOT_KW;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (!over && len == LEN_W'(KW_LEN[i]) && pfx == kw_pack(KW_STR[i], KW_LEN[i]))
        k = 5'(i);
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [2:0] cls, input logic [7:0] c1,
                                  input logic [7:0] c2, input logic [POS_W-1:0] row,
                                  input logic [POS_W-1:0] col, input logic [LEN_W-1:0] len,
                                  input logic over, input logic [7:0][7:0] pfx);
    tok_t t;
    t.cls  = cls;
    t.c1   = c1;
    t.c2   = c2;
    t.row  = row;
    t.col  = col;
    t.len  = len;
    t.over = over;
    t.pfx  = pfx;
    return t;
  endfunction

endpackage

### rtl/c_token_lexer.sv
// Top level of the C token lexer: scanner, token queue and output stage.
// A token passes through the bundle queue and then the output registers on its way to the outputs.
// Throughput: one byte per cycle while the queue is not full; a byte that completes two tokens has
// the output stage hand both out in turn, which the four-entry bundle queue absorbs.
// Reset (rst, synchronous): scanner idle at row 1, column 1; queue and output empty.
module c_token_lexer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_char,
  input  logic                      end_of_input,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                token_class,
  output logic [7:0]                first_char,
  output logic [7:0]                second_char,
  output logic [clx_pkg::POS_W-1:0] start_row,
  output logic [clx_pkg::POS_W-1:0] start_col,
  output logic [clx_pkg::LEN_W-1:0] lexeme_length,
  output logic [4:0]                keyword_index,
  output logic                      truncated,
  output logic                      last_of_run
);
  import clx_pkg::*;

  logic    take, push, pop, empty, full;
  bundle_t wr_bundle, head;

  // Hold off input only while the queue is full; a transfer advances the scanner.
  assign in_stall = full;
  assign take     = in_valid && !full;

  clx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .push         (push),
    .bundle       (wr_bundle)
  );

  // Bundles that carry no token are dropped before the queue.
  clx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_bundle),
    .pop     (pop),
    .rd_data (head),
    .empty   (empty),
    .full    (full)
  );

  clx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (!empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_class   (token_class),
    .first_char    (first_char),
    .second_char   (second_char),
    .start_row     (start_row),
    .start_col     (start_col),
    .lexeme_length (lexeme_length),
    .keyword_index (keyword_index),
    .truncated     (truncated),
    .last_of_run   (last_of_run)
  );

endmodule

### rtl/clx_front.sv
// Front end: scans one byte per transfer and forms the tokens it completes.
module clx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        in_char,
  input  logic              end_of_input,
  output logic              push,
  output clx_pkg::bundle_t  bundle
);
  import clx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SLASH, S_OP, S_NUM, S_IDENT, S_STR, S_LINE, S_BLOCK
  } mode_t;

  mode_t            mode, mode_next;
  logic [7:0]       pend_op, pend_op_next;
  logic             star, star_next;
  logic [POS_W-1:0] cur_row, cur_row_next, cur_col, cur_col_next;
  logic [POS_W-1:0] tok_row, tok_row_next, tok_col, tok_col_next;
  logic [LEN_W-1:0] tok_len, tok_len_next;
  logic             tok_over, tok_over_next;
  logic [7:0][7:0]  pfx, pfx_next;

  logic [7:0] c;
  logic       rescan, flush, is_digit, is_alpha, is_space, is_special, is_op;
  bundle_t    b;

  assign c          = in_char;
  assign is_digit   = c >= "0" && c <= "9";
  assign is_alpha   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_space   = c == " " || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  assign is_special = c == "#" || c == "?" || c == ";" || c == ":" || c == "," ||
                      c == "(" || c == ")" || c == "{" || c == "}" || c == ".";
  assign is_op      = c == "+" || c == "-" || c == "*" || c == "%" ||
                      c == "=" || c == "<" || c == ">" || c == "!";

  always_comb begin
    mode_next     = mode;
    pend_op_next  = pend_op;
    star_next     = star;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    tok_row_next  = tok_row;
    tok_col_next  = tok_col;
    tok_len_next  = tok_len;
    tok_over_next = tok_over;
    pfx_next      = pfx;
    rescan        = 1'b0;
    flush         = 1'b0;
    b             = '0;

    if (end_of_input) begin
      flush = 1'b1;
    end else begin
      unique case (mode)
        S_SLASH: begin
          if (c == "/") begin
            mode_next = S_LINE;
          end else if (c == "*") begin
            mode_next = S_BLOCK;
            star_next = 1'b0;
          end else begin
            flush  = 1'b1;
            rescan = 1'b1;
          end
          if (!rescan && cur_col != POS_CAP) cur_col_next = cur_col + 1'b1;
        end
        S_OP: begin
          if (c == "=" || ((pend_op == "+" || pend_op == "-") && c == pend_op)) begin
            b.tok[0] = mk_tok(CLS_OP, pend_op, c, tok_row, tok_col, 6'd2, 1'b0, pfx);
            b.n      = 2'd1;
            mode_next = S_IDLE;
            if (cur_col != POS_CAP) cur_col_next = cur_col + 1'b1;
          end else begin
            flush  = 1'b1;
            rescan = 1'b1;
          end
        end
        S_NUM, S_IDENT: begin
          if (is_digit || (mode == S_IDENT && (is_alpha || c == "_"))) begin
            if (tok_len < LEN_CAP) begin
              if (tok_len < LEN_W'(8)) pfx_next[tok_len[2:0]] = c;
              tok_len_next = tok_len + 1'b1;
            end else begin
              tok_over_next = 1'b1;
            end
            if (cur_col != POS_CAP) cur_col_next = cur_col + 1'b1;
          end else begin
            flush  = 1'b1;
            rescan = 1'b1;
          end
        end
        S_STR: begin
          if (tok_len < LEN_CAP) begin
            if (tok_len < LEN_W'(8)) pfx_next[tok_len[2:0]] = c;
            tok_len_next = tok_len + 1'b1;
          end else begin
            tok_over_next = 1'b1;
          end
          if (c == 8'h0a) begin
            if (cur_row != POS_CAP) cur_row_next = cur_row + 1'b1;
            cur_col_next = POS_W'(1);
          end else if (cur_col != POS_CAP) begin
            cur_col_next = cur_col + 1'b1;
          end
          if (c == "\"") flush = 1'b1;
        end
        S_LINE: begin
          if (c == 8'h0a) begin
            if (cur_row != POS_CAP) cur_row_next = cur_row + 1'b1;
            cur_col_next = POS_W'(1);
            mode_next    = S_IDLE;
          end else if (cur_col != POS_CAP) begin
            cur_col_next = cur_col + 1'b1;
          end
        end
        S_BLOCK: begin
          if (c == 8'h0a) begin
            if (cur_row != POS_CAP) cur_row_next = cur_row + 1'b1;
            cur_col_next = POS_W'(1);
          end else if (cur_col != POS_CAP) begin
            cur_col_next = cur_col + 1'b1;
          end
          if (star && c == "/") begin
            mode_next = S_IDLE;
            star_next = 1'b0;
          end else begin
            star_next = c == "*";
          end
        end
        S_IDLE: begin
          if (is_space) begin
            if (cur_col != POS_CAP) cur_col_next = cur_col + 1'b1;
          end else begin
            rescan = 1'b1;
          end
        end
        default: mode_next = S_IDLE;
      endcase
    end

    // Emit whatever token is still open.
    if (flush) begin
      unique case (mode)
        S_SLASH, S_OP: begin
          b.tok[0] = mk_tok(CLS_OP, pfx[0], 8'd0, tok_row, tok_col, 6'd1, 1'b0, pfx);
          b.n = 2'd1;
        end
        S_NUM: begin
          b.tok[0] = mk_tok(CLS_NUMBER, pfx[0], 8'd0, tok_row, tok_col, tok_len_next,
                            tok_over_next, pfx_next);
          b.n = 2'd1;
        end
        S_IDENT: begin
          b.tok[0] = mk_tok(CLS_IDENT, pfx[0], 8'd0, tok_row, tok_col, tok_len_next,
                            tok_over_next, pfx_next);
          b.n = 2'd1;
        end
        S_STR: begin
          b.tok[0] = mk_tok(CLS_STRING, pfx[0], 8'd0, tok_row, tok_col, tok_len_next,
                            tok_over_next, pfx_next);
          b.n = 2'd1;
        end
        default: ;
      endcase
      mode_next = S_IDLE;
    end

    if (end_of_input) begin
      star_next = 1'b0;
      b.tok[b.n[0]] = mk_tok(CLS_END, 8'd0, 8'd0, cur_row, cur_col, 6'd0, 1'b0, '0);
      b.n = b.n + 2'd1;
    end else if (rescan) begin
      // Scan the byte afresh from idle.
      if (c == 8'h0a) begin
        if (cur_row != POS_CAP) cur_row_next = cur_row + 1'b1;
        cur_col_next = POS_W'(1);
      end else begin
        if (c == "/" || is_op || is_digit || is_alpha || c == "_" || c == "\"") begin
          tok_row_next  = cur_row;
          tok_col_next  = cur_col;
          tok_len_next  = LEN_W'(1);
          tok_over_next = 1'b0;
          pfx_next      = '0;
          pfx_next[0]   = c;
        end
        if (c == "/") begin
          mode_next = S_SLASH;
        end else if (is_special) begin
          b.tok[b.n[0]] = mk_tok(CLS_SPECIAL, c, 8'd0, cur_row, cur_col, 6'd1, 1'b0, '0);
          b.n = b.n + 2'd1;
        end else if (is_op) begin
          pend_op_next = c;
          mode_next    = S_OP;
        end else if (is_digit) begin
          mode_next = S_NUM;
        end else if (is_alpha || c == "_") begin
          mode_next = S_IDENT;
        end else if (c == "\"") begin
          mode_next = S_STR;
        end
        if (cur_col != POS_CAP) cur_col_next = cur_col + 1'b1;
      end
    end
  end

  assign bundle = b;
  assign push   = take && b.n != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= S_IDLE;
      pend_op  <= 8'd0;
      star     <= 1'b0;
      cur_row  <= POS_W'(1);
      cur_col  <= POS_W'(1);
      tok_row  <= POS_W'(1);
      tok_col  <= POS_W'(1);
      tok_len  <= '0;
      tok_over <= 1'b0;
      pfx      <= '0;
    end else if (take) begin
      mode     <= mode_next;
      pend_op  <= pend_op_next;
      star     <= star_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      tok_row  <= tok_row_next;
      tok_col  <= tok_col_next;
      tok_len  <= tok_len_next;
      tok_over <= tok_over_next;
      pfx      <= pfx_next;
    end
  end

endmodule

### rtl/clx_queue.sv
// Short queue of token bundles between the scanner and the output stage.
module clx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clx_pkg::bundle_t  wr_data,
  input  logic              pop,
  output clx_pkg::bundle_t  rd_data,
  output logic              empty,
  output logic              full
);
  import clx_pkg::*;

  bundle_t        slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign empty   = count == '0;
  assign full    = count == (QAW+1)'(QDEPTH);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/clx_back.sv
// Back end: resolves keywords and hands tokens out one per transfer.
module clx_back (
  input  logic                     clk,
  input  logic                     rst,
  input  clx_pkg::bundle_t         head,
  input  logic                     head_valid,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               token_class,
  output logic [7:0]               first_char,
  output logic [7:0]               second_char,
  output logic [clx_pkg::POS_W-1:0] start_row,
  output logic [clx_pkg::POS_W-1:0] start_col,
  output logic [clx_pkg::LEN_W-1:0] lexeme_length,
  output logic [4:0]               keyword_index,
  output logic                     truncated,
  output logic                     last_of_run
);
  import clx_pkg::*;

  logic       sel;
  logic       load, is_last;
  tok_t       t;
  logic [4:0] kw;

  assign t       = head.tok[sel];
  assign is_last = head.n == {1'b0, 1'b1} + {1'b0, sel};
  assign kw      = (t.cls == CLS_IDENT) ? kw_lookup(t.pfx, t.len, t.over) : NOT_KW;
  assign load    = head_valid && (!out_valid || !out_stall);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      token_class   <= (kw != NOT_KW) ? CLS_KEYWORD : t.cls;
      first_char    <= t.c1;
      second_char   <= t.c2;
      start_row     <= t.row;
      start_col     <= t.col;
      lexeme_length <= t.len;
      keyword_index <= kw;
      truncated     <= t.over;
      last_of_run   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= is_last ? 1'b0 : 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
